[src/qti_pkg.sv]
// Shared types and constants of the quadratic table interpolator.
`timescale 1ns / 1ps
package qti_pkg;

   // Operation codes of a request word
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Status codes of a response word
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_FEW   = 3'd2;
   localparam logic [2:0] ST_ZERO  = 3'd3;
   localparam logic [2:0] ST_SAT   = 3'd4;

   // Arithmetic widths
   localparam int MC_W  = 66;   // multiplicand
   localparam int MP_W  = 34;   // multiplier
   localparam int PR_W  = 100;  // product and numerator magnitude
   localparam int NUM_W = 101;  // dividend
   localparam int DEN_W = 66;   // divisor
   localparam int QM_W  = 34;   // quotient bits that fit before saturation

   typedef enum logic [1:0] {
      RD_PREV = 2'd0,
      RD_CUR  = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      MUL_HD1  = 3'd0,
      MUL_P1A  = 3'd1,
      MUL_AB   = 3'd2,
      MUL_P2D2 = 3'd3,
      MUL_HH   = 3'd4
   } mul_sel_type;

   typedef enum logic [2:0] {
      RSP_OK     = 3'd0,
      RSP_FULL   = 3'd1,
      RSP_FEW    = 3'd2,
      RSP_ZERO   = 3'd3,
      RSP_INTERP = 3'd4
   } rsp_type;

   typedef struct packed {
      logic        capture;
      logic        idx_cnt;
      logic        idx_one;
      logic        idx_inc;
      logic        idx_dec;
      rd_sel_type  rd_sel;
      logic        wr_shift;
      logic        wr_new;
      logic        cnt_inc;
      logic        cnt_clr;
      logic        cap_xp;
      logic        cap_i;
      logic        cap_n;
      logic        prep;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        mul_cap;
      logic        sum;
      logic        div_start;
      logic        respond;
      rsp_type     rsp_sel;
   } qti_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   few;
      logic   idx_zero;
      logic   prev_gt;
      logic   search_end;
      logic   next_ge;
      logic   h_zero;
      logic   mul_busy;
      logic   div_busy;
   } qti_stat_type;

endpackage

[src/qti_mul.sv]
// Shift-and-add serial multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module qti_mul import qti_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [MC_W-1:0] mcand,
   input  logic [MP_W-1:0] mplier,
   output logic            busy,
   output logic [PR_W-1:0] product
);
   localparam int CNT_W = $clog2(MP_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [PR_W-1:0]  acc_ff;
   logic [PR_W-1:0]  mc_ff;
   logic [MP_W-1:0]  mp_ff;

   // Run the bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(MP_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Add the shifted multiplicand for each set multiplier bit
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mc_ff  <= PR_W'(mcand);
         mp_ff  <= mplier;
      end else if (busy_ff) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= {mc_ff[PR_W-2:0], 1'b0};
         mp_ff <= {1'b0, mp_ff[MP_W-1:1]};
      end
   end

   assign busy    = busy_ff;
   assign product = acc_ff;
endmodule

[src/qti_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module qti_div import qti_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] n_ff;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] r_ff;
   logic [DEN_W-1:0] d_ff;
   logic [DEN_W:0]   rs;
   logic             fits;

   assign rs   = {r_ff, n_ff[NUM_W-1]};
   assign fits = (rs >= {1'b0, d_ff});

   // Run the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Shift in one dividend bit and subtract where the divisor fits
   always_ff @(posedge clock) begin
      if (start) begin
         n_ff <= dividend;
         d_ff <= divisor;
         r_ff <= '0;
         q_ff <= '0;
      end else if (busy_ff) begin
         n_ff <= {n_ff[NUM_W-2:0], 1'b0};
         q_ff <= {q_ff[NUM_W-2:0], fits};
         if (fits) begin
            r_ff <= DEN_W'(rs - {1'b0, d_ff});
         end else begin
            r_ff <= rs[DEN_W-1:0];
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;
endmodule

[src/qti_dp.sv]
// Datapath: point tables, index and count, operand registers and arithmetic.
`timescale 1ns / 1ps
module qti_dp import qti_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_time_value,
   input  logic signed [31:0] req_sample_value,
   input  qti_cmd_type        cmd,
   output qti_stat_type       stat,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_interp_value,
   output logic [2:0]         rsp_status
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [31:0] t_mem [MAX_POINTS];
   logic [31:0] v_mem [MAX_POINTS];

   op_type             op_ff;
   logic signed [31:0] t0_ff, sv_ff;
   logic [CW-1:0]      cnt_ff, idx_ff;
   logic signed [31:0] rt_ff, rv_ff;
   logic signed [31:0] xp_ff, xi_ff, xn_ff, ti_ff, tn_ff;
   logic [32:0]        h_mag_ff, d1_mag_ff, a_mag_ff, b_mag_ff;
   logic [33:0]        d2_mag_ff;
   logic               h_zero_ff, s1_ff, s2_ff;
   logic [MC_W-1:0]    p1_ff, p2_ff, hh_ff;
   logic [PR_W-1:0]    m1_ff, m2_ff, mag_ff;
   logic               neg_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [2:0]         rsp_status_ff;

   logic [CW-1:0]      idx_prev, idx_next;
   logic [AW-1:0]      raddr, waddr;
   logic               wr_en;
   logic [31:0]        wt, wv;
   logic [MC_W-1:0]    mcand;
   logic [MP_W-1:0]    mplier;
   logic               mul_busy, div_busy;
   logic [PR_W-1:0]    product;
   logic [NUM_W-1:0]   quotient;
   logic signed [32:0] h_s, d1_s, a_s, b_s;
   logic signed [33:0] d2_s;
   logic signed [35:0] sum_s, q_s;
   logic               q_sat;

   assign idx_prev = idx_ff - 1'b1;
   assign idx_next = idx_ff + 1'b1;
   assign waddr    = idx_ff[AW-1:0];

   // Select the read address
   always_comb begin
      case (cmd.rd_sel)
         RD_PREV: raddr = idx_prev[AW-1:0];
         RD_NEXT: raddr = idx_next[AW-1:0];
         default: raddr = idx_ff[AW-1:0];
      endcase
   end

   assign wr_en = cmd.wr_shift | cmd.wr_new;
   assign wt    = cmd.wr_new ? t0_ff : rt_ff;
   assign wv    = cmd.wr_new ? sv_ff : rv_ff;

   // Write and read the point tables
   always_ff @(posedge clock) begin
      if (wr_en) begin
         t_mem[waddr] <= wt;
         v_mem[waddr] <= wv;
      end
      rt_ff <= t_mem[raddr];
      rv_ff <= v_mem[raddr];
   end

   // Hold the count and the walking index
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.idx_cnt) begin
            idx_ff <= cnt_ff;
         end else if (cmd.idx_one) begin
            idx_ff <= CW'(1);
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_next;
         end else if (cmd.idx_dec) begin
            idx_ff <= idx_prev;
         end
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= op_type'(req_op);
         t0_ff <= req_time_value;
         sv_ff <= req_sample_value;
      end
   end

   // Capture the three neighbor points
   always_ff @(posedge clock) begin
      if (cmd.cap_xp) begin
         xp_ff <= rv_ff;
      end
      if (cmd.cap_i) begin
         ti_ff <= rt_ff;
         xi_ff <= rv_ff;
      end
      if (cmd.cap_n) begin
         tn_ff <= rt_ff;
         xn_ff <= rv_ff;
      end
   end

   // Form spacing, differences and offsets
   assign h_s  = 33'(tn_ff) - 33'(ti_ff);
   assign d1_s = 33'(xn_ff) - 33'(xi_ff);
   assign d2_s = 34'(xn_ff) - (34'(xi_ff) <<< 1) + 34'(xp_ff);
   assign a_s  = 33'(t0_ff) - 33'(ti_ff);
   assign b_s  = 33'(t0_ff) - 33'(tn_ff);

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         h_zero_ff <= (h_s == '0);
         h_mag_ff  <= h_s[32] ? 33'(-h_s) : 33'(h_s);
         d1_mag_ff <= d1_s[32] ? 33'(-d1_s) : 33'(d1_s);
         d2_mag_ff <= d2_s[33] ? 34'(-d2_s) : 34'(d2_s);
         a_mag_ff  <= a_s[32] ? 33'(-a_s) : 33'(a_s);
         b_mag_ff  <= b_s[32] ? 33'(-b_s) : 33'(b_s);
         s1_ff     <= d1_s[32] ^ a_s[32] ^ h_s[32];
         s2_ff     <= d2_s[33] ^ a_s[32] ^ b_s[32];
      end
   end

   // Route multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_HD1: begin
            mcand  = MC_W'(h_mag_ff);
            mplier = MP_W'(d1_mag_ff);
         end
         MUL_P1A: begin
            mcand  = p1_ff;
            mplier = MP_W'(a_mag_ff);
         end
         MUL_AB: begin
            mcand  = MC_W'(a_mag_ff);
            mplier = MP_W'(b_mag_ff);
         end
         MUL_P2D2: begin
            mcand  = p2_ff;
            mplier = d2_mag_ff;
         end
         default: begin
            mcand  = MC_W'(h_mag_ff);
            mplier = MP_W'(h_mag_ff);
         end
      endcase
   end

   qti_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .mcand   (mcand),
      .mplier  (mplier),
      .busy    (mul_busy),
      .product (product)
   );

   // Store each finished product
   always_ff @(posedge clock) begin
      if (cmd.mul_cap) begin
         case (cmd.mul_sel)
            MUL_HD1:  p1_ff <= product[MC_W-1:0];
            MUL_P1A:  m1_ff <= {product[PR_W-2:0], 1'b0};
            MUL_AB:   p2_ff <= product[MC_W-1:0];
            MUL_P2D2: m2_ff <= product;
            default:  hh_ff <= product[MC_W-1:0];
         endcase
      end
   end

   // Combine the two signed terms into sign and magnitude
   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         if (s1_ff == s2_ff) begin
            mag_ff <= m1_ff + m2_ff;
            neg_ff <= s1_ff;
         end else if (m1_ff >= m2_ff) begin
            mag_ff <= m1_ff - m2_ff;
            neg_ff <= s1_ff;
         end else begin
            mag_ff <= m2_ff - m1_ff;
            neg_ff <= s2_ff;
         end
      end
   end

   qti_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (NUM_W'(mag_ff) + NUM_W'(hh_ff)),
      .divisor  ({hh_ff[DEN_W-2:0], 1'b0}),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // Add the rounded correction to the center value
   assign q_sat = |quotient[NUM_W-1:QM_W];
   assign q_s   = $signed({2'b00, quotient[QM_W-1:0]});
   assign sum_s = neg_ff ? (36'(xi_ff) - q_s) : (36'(xi_ff) + q_s);

   // Register the response word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_value_ff <= '0;
         case (cmd.rsp_sel)
            RSP_FULL: rsp_status_ff <= ST_FULL;
            RSP_FEW:  rsp_status_ff <= ST_FEW;
            RSP_ZERO: rsp_status_ff <= ST_ZERO;
            RSP_INTERP: begin
               if (q_sat) begin
                  rsp_value_ff  <= neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                  rsp_status_ff <= ST_SAT;
               end else if (sum_s > 36'sh0_7FFF_FFFF) begin
                  rsp_value_ff  <= 32'sh7FFF_FFFF;
                  rsp_status_ff <= ST_SAT;
               end else if (sum_s < -36'sh0_8000_0000) begin
                  rsp_value_ff  <= 32'sh8000_0000;
                  rsp_status_ff <= ST_SAT;
               end else begin
                  rsp_value_ff  <= sum_s[31:0];
                  rsp_status_ff <= ST_OK;
               end
            end
            default:  rsp_status_ff <= ST_OK;
         endcase
      end
   end

   // Report status to the controller
   always_comb begin
      stat.op         = op_ff;
      stat.full       = (cnt_ff >= CW'(MAX_POINTS));
      stat.few        = (cnt_ff < CW'(3));
      stat.idx_zero   = (idx_ff == '0);
      stat.prev_gt    = (rt_ff > t0_ff);
      stat.search_end = (({1'b0, idx_ff} + (CW+1)'(2)) >= {1'b0, cnt_ff});
      stat.next_ge    = (rt_ff >= t0_ff);
      stat.h_zero     = h_zero_ff;
      stat.mul_busy   = mul_busy;
      stat.div_busy   = div_busy;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
endmodule

[src/qti_ctrl.sv]
// Controller state machine that sequences load, search and interpolation.
`timescale 1ns / 1ps
module qti_ctrl import qti_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  qti_stat_type stat,
   output logic         busy,
   output qti_cmd_type  cmd
);
   typedef enum logic [19:0] {
      S_IDLE     = 20'h00001,
      S_DISPATCH = 20'h00002,
      S_LD_TOP   = 20'h00004,
      S_LD_RD    = 20'h00008,
      S_LD_CMP   = 20'h00010,
      S_QS_TOP   = 20'h00020,
      S_QS_RD    = 20'h00040,
      S_QS_CMP   = 20'h00080,
      S_QF0      = 20'h00100,
      S_QF1      = 20'h00200,
      S_QF2      = 20'h00400,
      S_QF3      = 20'h00800,
      S_PREP     = 20'h01000,
      S_CHK      = 20'h02000,
      S_MUL_GO   = 20'h04000,
      S_MUL_WAIT = 20'h08000,
      S_SUM      = 20'h10000,
      S_DIV_GO   = 20'h20000,
      S_DIV_WAIT = 20'h40000,
      S_FIN      = 20'h80000
   } state_type;

   state_type   state_ff, state_in;
   mul_sel_type step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= MUL_HD1;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Decode next state and commands
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd         = '0;
      cmd.rd_sel  = RD_CUR;
      cmd.mul_sel = step_ff;
      cmd.rsp_sel = RSP_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_LOAD: begin
                  if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_sel = RSP_FULL;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.idx_cnt = 1'b1;
                     state_in    = S_LD_TOP;
                  end
               end
               OP_QUERY: begin
                  if (stat.few) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_sel = RSP_FEW;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.idx_one = 1'b1;
                     state_in    = S_QS_TOP;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         // Walk down from the top, shifting larger times up one slot
         S_LD_TOP: begin
            if (stat.idx_zero) begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_LD_RD;
            end
         end
         S_LD_RD: begin
            cmd.rd_sel = RD_PREV;
            state_in   = S_LD_CMP;
         end
         S_LD_CMP: begin
            if (stat.prev_gt) begin
               cmd.wr_shift = 1'b1;
               cmd.idx_dec  = 1'b1;
               state_in     = S_LD_TOP;
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         // Search for the first following time at or above the query time
         S_QS_TOP: begin
            state_in = stat.search_end ? S_QF0 : S_QS_RD;
         end
         S_QS_RD: begin
            cmd.rd_sel = RD_NEXT;
            state_in   = S_QS_CMP;
         end
         S_QS_CMP: begin
            if (stat.next_ge) begin
               state_in = S_QF0;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_QS_TOP;
            end
         end
         // Fetch the three neighbor points
         S_QF0: begin
            cmd.rd_sel = RD_PREV;
            state_in   = S_QF1;
         end
         S_QF1: begin
            cmd.cap_xp = 1'b1;
            cmd.rd_sel = RD_CUR;
            state_in   = S_QF2;
         end
         S_QF2: begin
            cmd.cap_i  = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_in   = S_QF3;
         end
         S_QF3: begin
            cmd.cap_n = 1'b1;
            state_in  = S_PREP;
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            step_in = MUL_HD1;
            if (stat.h_zero) begin
               cmd.respond = 1'b1;
               cmd.rsp_sel = RSP_ZERO;
               state_in    = S_IDLE;
            end else begin
               state_in = S_MUL_GO;
            end
         end
         // Run the five products on the shared multiplier
         S_MUL_GO: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (!stat.mul_busy) begin
               cmd.mul_cap = 1'b1;
               case (step_ff)
                  MUL_HD1:  step_in = MUL_P1A;
                  MUL_P1A:  step_in = MUL_AB;
                  MUL_AB:   step_in = MUL_P2D2;
                  MUL_P2D2: step_in = MUL_HH;
                  default:  step_in = MUL_HD1;
               endcase
               state_in = (step_ff == MUL_HH) ? S_SUM : S_MUL_GO;
            end
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.respond = 1'b1;
            cmd.rsp_sel = RSP_INTERP;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);
endmodule

[src/quadratic_table_interpolator.sv]
// Top level of the quadratic table interpolator.
//
// A request word is taken at a rising edge with start high and busy low:
// req_op selects load (0), query (1) or clear (2); code 3 does nothing.
// Each request gives exactly one response word, shown for one cycle with
// rsp_valid high on rsp_interp_value and rsp_status; the receiver cannot
// stall it. Busy stays high from acceptance until the response is
// registered, so the next word may be started in the cycle rsp_valid shows.
// Sequence of a request from acceptance to the registered response:
//   clear, unused code, full table or too few points: answered at dispatch;
//   load: the new point is written at once when the table is empty, else after
//   the walk has moved each larger point up one slot;
//   query: one search step per table entry until a time at or above the query
//   time or the end of the table stops the search, then fetch and checks, five
//   products on the serial multiplier, and the sum and the serial divider.
//   Zero spacing answers after the checks.
// The insertion walk and the index search run one table entry per read of
// the single-port tables; the multiplier and divider are bit serial.
// Reset empties the table and returns the block to idle; table contents
// need no clearing since only entries below the count are read.
`timescale 1ns / 1ps
module quadratic_table_interpolator import qti_pkg::*; #(
   parameter int MAX_POINTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_time_value,
   input  logic signed [31:0] req_sample_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_interp_value,
   output logic [2:0]         rsp_status
);
   qti_cmd_type  cmd;
   qti_stat_type stat;

   qti_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   qti_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_time_value   (req_time_value),
      .req_sample_value (req_sample_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_interp_value (rsp_interp_value),
      .rsp_status       (rsp_status)
   );
endmodule

[tb/quadratic_table_interpolator_test.sv]
// Self-checking testbench of the quadratic table interpolator.
`timescale 1ns / 1ps
module quadratic_table_interpolator_test;
   import qti_pkg::*;

   localparam int TABLE_DEPTH = 64;
   localparam int STALL_LIMIT = 4000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = OP_NONE;
   logic signed [31:0] req_time_value = '0;
   logic signed [31:0] req_sample_value = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_interp_value;
   logic [2:0]         rsp_status;

   // Expected response words, oldest first
   logic signed [31:0] want_value_q[$];
   logic [2:0]         want_status_q[$];

   // Shadow copy of the point table
   logic signed [31:0] shadow_time[TABLE_DEPTH];
   logic signed [31:0] shadow_sample[TABLE_DEPTH];
   int                 shadow_count = 0;

   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  idle_enable = 1'b1;

   quadratic_table_interpolator #(.MAX_POINTS(TABLE_DEPTH)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_time_value(req_time_value),
      .req_sample_value(req_sample_value), .rsp_valid(rsp_valid),
      .rsp_interp_value(rsp_interp_value), .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // Interpolate at t0 over the shadow table, exact over 2h^2
   task automatic interpolate(input logic signed [31:0] t0,
                              output logic signed [31:0] value,
                              output logic [2:0] status);
      int                  idx;
      logic signed [63:0]  h, d1, d2, a, b, xi;
      logic signed [199:0] num, den, mag_num, quot, sum;
      value = '0;
      status = ST_OK;
      if (shadow_count < 3) begin
         status = ST_FEW;
         return;
      end
      idx = 1;
      while (idx < shadow_count - 2 && shadow_time[idx + 1] < t0) idx++;
      h = 64'(shadow_time[idx + 1]) - 64'(shadow_time[idx]);
      if (h == 0) begin
         status = ST_ZERO;
         return;
      end
      xi = shadow_sample[idx];
      d1 = 64'(shadow_sample[idx + 1]) - xi;
      d2 = 64'(shadow_sample[idx + 1]) - 2 * xi + 64'(shadow_sample[idx - 1]);
      a = 64'(t0) - 64'(shadow_time[idx]);
      b = 64'(t0) - 64'(shadow_time[idx + 1]);
      num = 2 * 200'(h) * 200'(d1) * 200'(a) + 200'(a) * 200'(b) * 200'(d2);
      den = 2 * 200'(h) * 200'(h);
      // round half away from zero
      mag_num = num < 0 ? -num : num;
      quot = (2 * mag_num + den) / (2 * den);
      if (quot >= (200'sd1 <<< 34)) begin
         value = num < 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
         status = ST_SAT;
         return;
      end
      sum = 200'(xi) + (num < 0 ? -quot : quot);
      if (sum > 200'sh7fff_ffff) begin
         value = 32'sh7fff_ffff;
         status = ST_SAT;
      end else if (sum < -200'sh8000_0000) begin
         value = 32'sh8000_0000;
         status = ST_SAT;
      end else begin
         value = sum[31:0];
      end
   endtask

   // Apply one word to the shadow table and queue its response
   task automatic predict_word(input logic [1:0] op, input logic signed [31:0] tv,
                               input logic signed [31:0] sv);
      logic signed [31:0] value;
      logic [2:0]         status;
      int                 pos;
      value = '0;
      status = ST_OK;
      case (op)
         OP_LOAD: begin
            if (shadow_count >= TABLE_DEPTH) begin
               status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_time[pos] <= tv) pos++;
               for (int k = shadow_count; k > pos; k--) begin
                  shadow_time[k] = shadow_time[k - 1];
                  shadow_sample[k] = shadow_sample[k - 1];
               end
               shadow_time[pos] = tv;
               shadow_sample[pos] = sv;
               shadow_count++;
            end
         end
         OP_QUERY: interpolate(tv, value, status);
         OP_CLEAR: shadow_count = 0;
         default: ;
      endcase
      want_value_q.push_back(value);
      want_status_q.push_back(status);
   endtask

   // Send one word and hold until it is taken; drop start only before a gap
   task automatic send_word(input logic [1:0] op, input logic signed [31:0] tv,
                            input logic signed [31:0] sv);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= op;
      req_time_value <= tv;
      req_sample_value <= sv;
      start <= 1'b1;
      predict_word(op, tv, sv);
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 4))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 32'($urandom_range(0, 64)) - 32;
         default: return $urandom;
      endcase
   endfunction

   // Check each response word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (want_value_q.size() == 0) begin
            $display("%0t: unexpected word value %0d status %0d",
                     $realtime, rsp_interp_value, rsp_status);
            error_count++;
         end else begin
            if (rsp_interp_value !== want_value_q[0]) begin
               $display("%0t: value expected %0d actual %0d",
                        $realtime, want_value_q[0], rsp_interp_value);
               error_count++;
            end
            if (rsp_status !== want_status_q[0]) begin
               $display("%0t: status expected %0d actual %0d",
                        $realtime, want_status_q[0], rsp_status);
               error_count++;
            end
            void'(want_value_q.pop_front());
            void'(want_status_q.pop_front());
         end
      end
   end

   // Watchdog: count cycles with nothing accepted or answered
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Extremes, every op, too few points, zero spacing, clamp, saturation, full
   task automatic test_directed();
      send_word(OP_QUERY, 0, 0);
      send_word(OP_NONE, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_word(OP_LOAD, 32'sh8000_0000, 32'sh7fff_ffff);
      send_word(OP_LOAD, 32'sh7fff_ffff, 32'sh8000_0000);
      send_word(OP_QUERY, 0, 0);
      send_word(OP_LOAD, 0, 32'sh7fff_ffff);
      send_word(OP_QUERY, 32'sh4000_0000, 0);
      send_word(OP_QUERY, 32'sh8000_0000, 0);
      send_word(OP_QUERY, 32'sh7fff_ffff, 0);
      send_word(OP_LOAD, 0, 5);
      send_word(OP_QUERY, 0, 0);
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_LOAD, 32'h0001_0000, 32'h0001_0000);
      send_word(OP_LOAD, 32'h0002_0000, 32'h0004_0000);
      send_word(OP_LOAD, 32'h0003_0000, 32'h0009_0000);
      send_word(OP_QUERY, 32'h0002_8000, 0);
      send_word(OP_QUERY, 32'h0010_0000, 0);
      send_word(OP_CLEAR, 0, 0);
      for (int k = 0; k < TABLE_DEPTH + 2; k++)
         send_word(OP_LOAD, $urandom, $urandom);
      send_word(OP_QUERY, $urandom, 0);
      send_word(OP_CLEAR, 0, 0);
   endtask

   // Build small tables and query them, with some noise mixed in
   task automatic test_random(input int words);
      int sent, fill;
      logic signed [31:0] base;
      sent = 0;
      while (sent < words) begin
         if (sent > words * 4 / 5) idle_enable = 1'b0;
         send_word(OP_CLEAR, rand_word(), rand_word());
         fill = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(3, 6);
         base = $urandom_range(0, 1) ? 32'sd0 : 32'($urandom);
         sent++;
         for (int k = 0; k < fill && sent < words; k++, sent++) begin
            if ($urandom_range(0, 1))
               send_word(OP_LOAD, base + 32'($urandom_range(0, 8) * 32'h8000),
                         $urandom_range(0, 1) ? rand_word() : 32'($urandom_range(0, 9)) << 16);
            else
               send_word(OP_LOAD, rand_word(), rand_word());
         end
         for (int k = $urandom_range(1, 6); k > 0 && sent < words; k--, sent++) begin
            case ($urandom_range(0, 9))
               0: send_word(OP_NONE, rand_word(), rand_word());
               1: send_word(OP_QUERY, rand_word(), rand_word());
               default: send_word(OP_QUERY, base + 32'($urandom_range(0, 10) * 32'h4000),
                                  rand_word());
            endcase
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1350);
      start <= 1'b0;
      while (want_value_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
